[rtl/core/tbos_pkg.sv]
// Shared request codes and status codes of the typed byte operand stack.
`timescale 1ns / 1ps
`default_nettype none

package tbos_pkg;

   // Request code carried on req_type.
   typedef logic [2:0] op_type;

   // Status code carried on rsp_status.
   typedef logic [1:0] status_type;

   localparam op_type OP_PUSH   = 3'd0;
   localparam op_type OP_POP    = 3'd1;
   localparam op_type OP_PEEK   = 3'd2;
   localparam op_type OP_READ   = 3'd3;
   localparam op_type OP_WRITE  = 3'd4;
   localparam op_type OP_GROW   = 3'd5;
   localparam op_type OP_SHRINK = 3'd6;
   localparam op_type OP_SET    = 3'd7;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_FULL    = 2'd1;
   localparam status_type ST_SHORT   = 2'd2;
   localparam status_type ST_OUTSIDE = 2'd3;

   // Widest value moved by one request, in bytes.
   localparam logic [3:0] MAX_BYTES = 4'd8;

endpackage

`default_nettype wire

[rtl/core/typed_byte_operand_stack_top.sv]
// Byte-addressed operand stack: a byte-wide store stepped by a small sequencer.
//
// The req_ channel carries one transaction per request: push, pop, peek,
// read at, write at, grow, shrink or set top, with a size of 0 to 8 bytes
// (larger sizes saturate to 8), a location or amount, and a write value.
// The rsp_ channel returns one transaction per request with the read value,
// the position and a status code. A request that fails its check changes
// nothing and returns a zero value and position with its status.
// The request is checked first, then the single byte port of the store is
// stepped once per value byte; a read-type request then waits for its last
// registered read byte before the result is loaded. Requests that move no
// bytes go from the check straight to the final step. The block takes one
// request at a time and raises req_ready in the cycle right after the edge
// that loads the output register.
// If rsp_ready is held low, the finished result waits in the output
// register; a following request is accepted and worked, and holds in its
// final step until the output register is free.
// After reset the store is cleared one byte per cycle, with req_ready low;
// the top pointer is zero at once.
`timescale 1ns / 1ps
`default_nettype none

module typed_byte_operand_stack_top #(
   parameter int STACK_BYTES = 256
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_ready,
   input  wire  [2:0]   req_type,
   input  wire  [3:0]   req_access_size,
   input  wire  [8:0]   req_location,
   input  wire  [63:0]  req_write_value,
   output logic         rsp_valid,
   input  wire          rsp_ready,
   output logic [63:0]  rsp_read_value,
   output logic [8:0]   rsp_position,
   output logic [1:0]   rsp_status
);

   // Address width of the store and width of the top pointer (0..STACK_BYTES).
   localparam int AW = $clog2(STACK_BYTES);
   localparam int TW = $clog2(STACK_BYTES + 1);
   // Check arithmetic width: room for top plus a 9-bit amount without wrap.
   localparam int CW = ((TW > 9) ? TW : 9) + 1;

   // Sequencer state codes.
   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_CHECK  = 3'd2;
   localparam logic [2:0] S_ACCESS = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   // Byte store.
   logic [7:0]          mem [STACK_BYTES];
   logic [7:0]          mem_rdata_ff;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic [AW-1:0]       mem_raddr;
   logic [7:0]          mem_wdata;

   // Control registers.
   logic [2:0]          state_ff, state_in;
   logic [AW-1:0]       clr_addr_ff, clr_addr_in;
   logic [TW-1:0]       top_ff, top_in;
   logic                rd_pend_ff, rd_pend_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Request and working registers.
   tbos_pkg::op_type    op_ff, op_in;
   logic [3:0]          size_ff, size_in;
   logic [8:0]          loc_ff, loc_in;
   logic [63:0]         wdata_ff, wdata_in;
   logic [63:0]         rdata_ff, rdata_in;
   logic [TW-1:0]       base_ff, base_in;
   logic [2:0]          cnt_ff, cnt_in;
   logic [2:0]          rd_idx_ff, rd_idx_in;
   logic                is_write_ff, is_write_in;
   logic [8:0]          pos_ff, pos_in;
   tbos_pkg::status_type st_ff, st_in;

   // Output register.
   logic [63:0]         rsp_value_ff, rsp_value_in;
   logic [8:0]          rsp_pos_ff, rsp_pos_in;
   tbos_pkg::status_type rsp_status_ff, rsp_status_in;

   // Check arithmetic on the registered request.
   logic [CW-1:0]       top_x, loc_x, n_x, cap_x;
   logic [CW-1:0]       add_src, sub_src, top_add, top_sub, loc_end;
   logic                top_short;
   logic [CW-1:0]       new_top, new_base, new_pos;
   logic                chk_ok, chk_move, chk_write;
   tbos_pkg::status_type chk_st;
   logic                last_byte;
   logic [TW-1:0]       acc_addr;

   assign top_x = CW'(top_ff);
   assign loc_x = CW'(loc_ff);
   assign n_x   = CW'(size_ff);
   assign cap_x = CW'(STACK_BYTES);

   assign add_src   = (op_ff == tbos_pkg::OP_PUSH) ? n_x : loc_x;
   assign sub_src   = ((op_ff == tbos_pkg::OP_POP) || (op_ff == tbos_pkg::OP_PEEK))
                      ? n_x : loc_x;
   assign top_add   = top_x + add_src;
   assign top_sub   = top_x - sub_src;
   assign top_short = (top_x < sub_src);
   assign loc_end   = loc_x + n_x;

   // Decide status, new top, byte range and position for the request.
   always_comb begin
      chk_st    = tbos_pkg::ST_OK;
      new_top   = top_x;
      new_base  = top_x;
      new_pos   = '0;
      chk_move  = 1'b0;
      chk_write = 1'b0;
      case (op_ff)
         tbos_pkg::OP_PUSH: begin
            if (top_add > cap_x) begin
               chk_st = tbos_pkg::ST_FULL;
            end else begin
               new_base  = top_x;
               new_pos   = top_x;
               new_top   = top_add;
               chk_move  = 1'b1;
               chk_write = 1'b1;
            end
         end
         tbos_pkg::OP_POP: begin
            if (top_short) begin
               chk_st = tbos_pkg::ST_SHORT;
            end else begin
               new_base = top_sub;
               new_pos  = top_sub;
               new_top  = top_sub;
               chk_move = 1'b1;
            end
         end
         tbos_pkg::OP_PEEK: begin
            if (top_short) begin
               chk_st = tbos_pkg::ST_SHORT;
            end else begin
               new_base = top_sub;
               new_pos  = top_sub;
               chk_move = 1'b1;
            end
         end
         tbos_pkg::OP_READ: begin
            if (loc_end > top_x) begin
               chk_st = tbos_pkg::ST_OUTSIDE;
            end else begin
               new_base = loc_x;
               new_pos  = loc_x;
               chk_move = 1'b1;
            end
         end
         tbos_pkg::OP_WRITE: begin
            if (loc_end > top_x) begin
               chk_st = tbos_pkg::ST_OUTSIDE;
            end else begin
               new_base  = loc_x;
               new_pos   = loc_x;
               chk_move  = 1'b1;
               chk_write = 1'b1;
            end
         end
         tbos_pkg::OP_GROW: begin
            if (top_add > cap_x) begin
               chk_st = tbos_pkg::ST_FULL;
            end else begin
               new_top = top_add;
               new_pos = top_add;
            end
         end
         tbos_pkg::OP_SHRINK: begin
            if (top_short) begin
               chk_st = tbos_pkg::ST_SHORT;
            end else begin
               new_top = top_sub;
               new_pos = top_sub;
            end
         end
         default: begin
            if (loc_x > cap_x) begin
               chk_st = tbos_pkg::ST_FULL;
            end else begin
               new_top = loc_x;
               new_pos = loc_x;
            end
         end
      endcase
   end

   assign chk_ok    = (chk_st == tbos_pkg::ST_OK);
   assign last_byte = ({1'b0, cnt_ff} == (size_ff - 4'd1));
   assign acc_addr  = base_ff + TW'(cnt_ff);

   // Store port selection: the clearing pass owns the write port after reset.
   assign mem_we    = (state_ff == S_CLEAR) || ((state_ff == S_ACCESS) && is_write_ff);
   assign mem_waddr = (state_ff == S_CLEAR) ? clr_addr_ff : acc_addr[AW-1:0];
   assign mem_wdata = (state_ff == S_CLEAR) ? 8'h00 : wdata_ff[7:0];
   assign mem_raddr = acc_addr[AW-1:0];

   // Byte store with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_raddr];
   end

   // Sequencer next-state logic.
   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      top_in        = top_ff;
      rd_pend_in    = 1'b0;
      rsp_valid_in  = rsp_valid_ff;
      op_in         = op_ff;
      size_in       = size_ff;
      loc_in        = loc_ff;
      wdata_in      = wdata_ff;
      rdata_in      = rdata_ff;
      base_in       = base_ff;
      cnt_in        = cnt_ff;
      rd_idx_in     = rd_idx_ff;
      is_write_in   = is_write_ff;
      pos_in        = pos_ff;
      st_in         = st_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_status_in = rsp_status_ff;

      // The output register frees as soon as its transaction is taken.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // A byte read issued last cycle lands in its place in the value.
      if (rd_pend_ff) begin
         rdata_in[{rd_idx_ff, 3'b000} +: 8] = mem_rdata_ff;
      end

      case (state_ff)
         S_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(STACK_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_type;
               size_in  = (req_access_size > tbos_pkg::MAX_BYTES)
                          ? tbos_pkg::MAX_BYTES : req_access_size;
               loc_in   = req_location;
               wdata_in = req_write_value;
               rdata_in = '0;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            st_in       = chk_st;
            cnt_in      = '0;
            is_write_in = chk_write;
            base_in     = new_base[TW-1:0];
            if (chk_ok) begin
               top_in = new_top[TW-1:0];
               pos_in = new_pos[8:0];
            end else begin
               pos_in = '0;
            end
            if (chk_ok && chk_move && (size_ff != 4'd0)) begin
               state_in = S_ACCESS;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_ACCESS: begin
            // One byte per cycle through the single store port.
            cnt_in = cnt_ff + 3'd1;
            if (is_write_ff) begin
               wdata_in = wdata_ff >> 8;
            end else begin
               rd_pend_in = 1'b1;
               rd_idx_in  = cnt_ff;
            end
            if (last_byte) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rd_pend_ff && (!rsp_valid_ff || rsp_ready)) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = rdata_ff;
               rsp_pos_in    = pos_ff;
               rsp_status_in = st_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         top_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         top_ff       <= top_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      size_ff       <= size_in;
      loc_ff        <= loc_in;
      wdata_ff      <= wdata_in;
      rdata_ff      <= rdata_in;
      base_ff       <= base_in;
      cnt_ff        <= cnt_in;
      rd_idx_ff     <= rd_idx_in;
      is_write_ff   <= is_write_in;
      pos_ff        <= pos_in;
      st_ff         <= st_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Ports.
   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_position   = rsp_pos_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

`default_nettype wire
